// ===== hdl/rrla_pkg.sv =====
// ----------------------------------------------------------------------------
// rrla_pkg
// Shared codes and the control word that walks the cell row of the lock
// arbiter.
// ----------------------------------------------------------------------------
package rrla_pkg;

    localparam int OP_W       = 3;
    localparam int NODE_W     = 4;
    localparam int ST_W       = 2;
    localparam int OUT_ADDR_W = 48;
    localparam int IN_ADDR_W  = 48;
    // wide enough for any slot index and any node number
    localparam int IDX_CMP_W  = 6;

    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE    = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_ISSUED = 3'd4;

    localparam logic [ST_W-1:0] ST_OK           = 2'd0;
    localparam logic [ST_W-1:0] ST_ADD_TAKEN    = 2'd1;
    localparam logic [ST_W-1:0] ST_REMOVE_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_ADVANCE_NONE = 2'd3;

    typedef struct packed {
        logic              act;
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] node;
        logic [ST_W-1:0]   status;
        logic              rm_done;
        logic              any_v;
        logic              succ;
        logic              hi_found;
        logic              lo_found;
    } t_ctrl;

endpackage

// ===== hdl/rrla_cell.sv =====
// ----------------------------------------------------------------------------
// rrla_cell
// One request slot: valid bit and line address. Updates itself when the
// word passes and folds its post-operation view into the word for the next.
// ----------------------------------------------------------------------------
module rrla_cell #(
    parameter int IDX       = 0,
    parameter int NODES     = 16,
    parameter int ADDR_BITS = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [$clog2(NODES)-1:0] i_holder,
    input  rrla_pkg::t_ctrl          i_ctrl,
    input  logic [ADDR_BITS-1:0]     i_addr,
    input  logic [$clog2(NODES)-1:0] i_hi_idx,
    input  logic [$clog2(NODES)-1:0] i_lo_idx,
    input  logic [ADDR_BITS-1:0]     i_res_addr,
    input  logic [ADDR_BITS-1:0]     i_lo_addr,
    output rrla_pkg::t_ctrl          o_ctrl,
    output logic [ADDR_BITS-1:0]     o_addr,
    output logic [$clog2(NODES)-1:0] o_hi_idx,
    output logic [$clog2(NODES)-1:0] o_lo_idx,
    output logic [ADDR_BITS-1:0]     o_res_addr,
    output logic [ADDR_BITS-1:0]     o_lo_addr
);

    localparam int IW = $clog2(NODES);
    localparam logic [rrla_pkg::IDX_CMP_W-1:0] MY_IDX = rrla_pkg::IDX_CMP_W'(IDX);

    logic                 r_valid;
    logic [ADDR_BITS-1:0] r_addr;

    rrla_pkg::t_ctrl      r_ctrl, n_ctrl;
    logic [ADDR_BITS-1:0] r_tok_addr;
    logic [IW-1:0]        r_hi_idx, n_hi_idx;
    logic [IW-1:0]        r_lo_idx, n_lo_idx;
    logic [ADDR_BITS-1:0] r_res_addr, n_res_addr;
    logic [ADDR_BITS-1:0] r_lo_addr, n_lo_addr;

    logic                 hit;
    logic                 wr;
    logic                 n_valid;
    logic [ADDR_BITS-1:0] post_addr;
    logic [rrla_pkg::IDX_CMP_W-1:0] node_x;
    logic [rrla_pkg::IDX_CMP_W-1:0] holder_x;

    always_comb begin
        node_x    = rrla_pkg::IDX_CMP_W'(i_ctrl.node);
        holder_x  = rrla_pkg::IDX_CMP_W'(i_holder);
        hit       = i_ctrl.act && (node_x == MY_IDX);
        wr        = hit && (i_ctrl.op == rrla_pkg::OP_ADD) && !r_valid;
        post_addr = wr ? i_addr : r_addr;
        n_valid   = r_valid;
        n_ctrl     = i_ctrl;
        n_hi_idx   = i_hi_idx;
        n_lo_idx   = i_lo_idx;
        n_res_addr = i_res_addr;
        n_lo_addr  = i_lo_addr;

        if (hit) begin
            case (i_ctrl.op)
                rrla_pkg::OP_ADD: begin
                    if (r_valid) begin
                        n_ctrl.status = rrla_pkg::ST_ADD_TAKEN;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
                rrla_pkg::OP_REMOVE: begin
                    if (r_valid) begin
                        n_valid        = 1'b0;
                        n_ctrl.rm_done = 1'b1;
                    end else begin
                        n_ctrl.status = rrla_pkg::ST_REMOVE_EMPTY;
                    end
                end
                default: begin
                end
            endcase
        end

        n_ctrl.any_v = i_ctrl.any_v | n_valid;
        if (n_valid && (MY_IDX > node_x) && (post_addr == i_addr)) begin
            n_ctrl.succ = 1'b1;
        end

        if (i_ctrl.op == rrla_pkg::OP_ADVANCE) begin
            // first valid above the holder wins, else first valid at or below
            if (n_valid && (MY_IDX > holder_x) && !i_ctrl.hi_found) begin
                n_ctrl.hi_found = 1'b1;
                n_hi_idx        = IW'(IDX);
                n_res_addr      = post_addr;
            end
            if (n_valid && (MY_IDX <= holder_x) && !i_ctrl.lo_found) begin
                n_ctrl.lo_found = 1'b1;
                n_lo_idx        = IW'(IDX);
                n_lo_addr       = post_addr;
            end
        end else if (MY_IDX == holder_x) begin
            n_res_addr = post_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctrl  <= '0;
        end else begin
            r_valid <= n_valid;
            r_ctrl  <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_addr <= i_addr;
        end
        r_tok_addr <= i_addr;
        r_hi_idx   <= n_hi_idx;
        r_lo_idx   <= n_lo_idx;
        r_res_addr <= n_res_addr;
        r_lo_addr  <= n_lo_addr;
    end

    assign o_ctrl     = r_ctrl;
    assign o_addr     = r_tok_addr;
    assign o_hi_idx   = r_hi_idx;
    assign o_lo_idx   = r_lo_idx;
    assign o_res_addr = r_res_addr;
    assign o_lo_addr  = r_lo_addr;

endmodule

// ===== hdl/round_robin_lock_arbiter.sv =====
// Path of a word: head register, the NODES cells, result register, output register.
// A new word is taken only after the last one's result has left the result register.
// The request word walks the row of NODES slot cells, one cell per cycle.
// A result may wait on the master side while the next word is already accepted.
// Reset: all slots empty, holder NODES-1, grant released, issued address zero.
// ----------------------------------------------------------------------------
// round_robin_lock_arbiter
// Lock arbiter with one request slot per node and a round-robin grant; the
// slots form a cell row that each request word sweeps from slot zero up.
// ----------------------------------------------------------------------------
module round_robin_lock_arbiter #(
    parameter int NODES     = 16,
    parameter int ADDR_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // node[3:0], line_address[51:4], zero[55:52]
    input  logic [2:0]  i_s_tuser,  // operation[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // busy_res[0], holder_node[4:1], holder_address[52:5], any_request[53],
    // successor_found[54], issued_match[55]
    output logic [55:0] o_m_tdata,
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    localparam int IW = $clog2(NODES);
    localparam logic [IW-1:0] HOLDER_RST = IW'(NODES - 1);

    // request word chain, entry 0 is the head register, entry NODES the exit
    rrla_pkg::t_ctrl      c_ctrl     [NODES+1];
    logic [ADDR_BITS-1:0] c_addr     [NODES+1];
    logic [IW-1:0]        c_hi_idx   [NODES+1];
    logic [IW-1:0]        c_lo_idx   [NODES+1];
    logic [ADDR_BITS-1:0] c_res_addr [NODES+1];
    logic [ADDR_BITS-1:0] c_lo_addr  [NODES+1];
    logic [NODES:0]       act_vec;

    rrla_pkg::t_ctrl      r_head, n_head;
    logic [ADDR_BITS-1:0] r_head_addr;
    logic                 r_chain_busy;
    logic                 r_busy, n_busy;
    logic [IW-1:0]        r_holder, n_holder;
    logic [ADDR_BITS-1:0] r_issued;

    logic                 r_res_v;
    logic [55:0]          r_res_data;
    logic [1:0]           r_res_user;
    logic                 r_out_v;
    logic [55:0]          r_out_data;
    logic [1:0]           r_out_user;

    logic                 s_acc;
    logic                 res_move;
    logic [ADDR_BITS-1:0] in_addr;
    logic [ADDR_BITS-1:0] sel_addr;
    logic [rrla_pkg::ST_W-1:0]       x_status;
    logic [rrla_pkg::OUT_ADDR_W-1:0] x_haddr;
    logic                 x_match;
    rrla_pkg::t_ctrl      x;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_chain_busy && !r_res_v;
    assign in_addr    = ADDR_BITS'(i_s_tdata[51:4]);

    assign c_ctrl[0]     = r_head;
    assign c_addr[0]     = r_head_addr;
    assign c_hi_idx[0]   = '0;
    assign c_lo_idx[0]   = '0;
    assign c_res_addr[0] = '0;
    assign c_lo_addr[0]  = '0;

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        rrla_cell #(
            .IDX       (g),
            .NODES     (NODES),
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_holder   (r_holder),
            .i_ctrl     (c_ctrl[g]),
            .i_addr     (c_addr[g]),
            .i_hi_idx   (c_hi_idx[g]),
            .i_lo_idx   (c_lo_idx[g]),
            .i_res_addr (c_res_addr[g]),
            .i_lo_addr  (c_lo_addr[g]),
            .o_ctrl     (c_ctrl[g+1]),
            .o_addr     (c_addr[g+1]),
            .o_hi_idx   (c_hi_idx[g+1]),
            .o_lo_idx   (c_lo_idx[g+1]),
            .o_res_addr (c_res_addr[g+1]),
            .o_lo_addr  (c_lo_addr[g+1])
        );
    end

    for (genvar g = 0; g <= NODES; g++) begin : g_act
        assign act_vec[g] = c_ctrl[g].act;
    end

    always_comb begin
        n_head     = '0;
        n_head.act = s_acc;
        if (s_acc) begin
            n_head.op     = i_s_tuser;
            n_head.node   = i_s_tdata[3:0];
            n_head.status = rrla_pkg::ST_OK;
        end
    end

    // resolve the word leaving the last cell
    always_comb begin
        x        = c_ctrl[NODES];
        n_busy   = r_busy;
        n_holder = r_holder;
        x_status = x.status;
        sel_addr = c_res_addr[NODES];
        if (x.op == rrla_pkg::OP_ADVANCE) begin
            if (x.hi_found) begin
                n_busy   = 1'b1;
                n_holder = c_hi_idx[NODES];
            end else if (x.lo_found) begin
                n_busy   = 1'b1;
                n_holder = c_lo_idx[NODES];
                sel_addr = c_lo_addr[NODES];
            end else begin
                n_busy   = 1'b0;
                x_status = rrla_pkg::ST_ADVANCE_NONE;
            end
        end else if (x.rm_done && !x.any_v) begin
            n_busy = 1'b0;
        end
        x_haddr = n_busy ? rrla_pkg::OUT_ADDR_W'(sel_addr) : '0;
        x_match = (r_issued == c_addr[NODES]);
    end

    assign res_move = r_res_v && (!r_out_v || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_chain_busy <= 1'b0;
            r_busy       <= 1'b0;
            r_holder     <= HOLDER_RST;
            r_issued     <= '0;
            r_res_v      <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_head <= n_head;
            if (s_acc) begin
                r_chain_busy <= 1'b1;
                if (i_s_tuser == rrla_pkg::OP_SET_ISSUED) begin
                    r_issued <= in_addr;
                end
            end
            if (x.act) begin
                r_busy       <= n_busy;
                r_holder     <= n_holder;
                r_chain_busy <= 1'b0;
                r_res_v      <= 1'b1;
            end else if (res_move) begin
                r_res_v <= 1'b0;
            end
            if (res_move) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_addr <= in_addr;
        if (x.act) begin
            r_res_user <= x_status;
            r_res_data <= {x_match, x.succ, x.any_v, x_haddr,
                           rrla_pkg::NODE_W'(n_holder), n_busy};
        end
        if (res_move) begin
            r_out_data <= r_res_data;
            r_out_user <= r_res_user;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(act_vec) <= 1)
        else $error("more than one request word in the cell row");

    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x.act |-> (r_chain_busy && !r_res_v))
        else $error("word left the row without an open slot for its result");

    a_holder_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_holder) <= NODES - 1)
        else $error("holder index out of range");

    a_no_accept_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act_vec != '0) |-> !o_s_tready)
        else $error("input ready while a word is in the row");

endmodule

// ===== bench/lock_arbiter_checker.sv =====
// ----------------------------------------------------------------------------
// lock_arbiter_checker
// Watches both stream channels of the round-robin lock arbiter. It keeps its
// own copy of the slot table, holder, grant and issued address. It predicts
// one result word per accepted request and compares each field in order.
// ----------------------------------------------------------------------------
module lock_arbiter_checker #(
    parameter int NODES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,   // node[3:0], line_address[51:4], zero[55:52]
    input  logic [2:0]  i_s_tuser,   // operation[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // busy_res[0], holder_node[4:1], holder_address[52:5], any_request[53],
    // successor_found[54], issued_match[55]
    input  logic [55:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,   // status[1:0]
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rrla_pkg::ST_W-1:0]       status;
        logic                            busy;
        logic [rrla_pkg::NODE_W-1:0]     holder;
        logic [rrla_pkg::OUT_ADDR_W-1:0] holder_addr;
        logic                            any_req;
        logic                            succ;
        logic                            issued_hit;
    } t_lock_result;

    logic                           slot_valid [NODES];
    logic [rrla_pkg::IN_ADDR_W-1:0] slot_addr  [NODES];
    int                             holder_idx;
    logic                           grant_busy;
    logic [rrla_pkg::IN_ADDR_W-1:0] issued_addr;

    t_lock_result lock_results_q[$];
    t_lock_result want_r;
    t_lock_result got_r;
    int           n_fail = 0;

    function automatic logic any_slot();
        int i;
        for (i = 0; i < NODES; i++) begin
            if (slot_valid[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Update the slot table for one request and return the word it should produce.
    function automatic t_lock_result apply_lock_op(
        input logic [rrla_pkg::OP_W-1:0]      op,
        input logic [rrla_pkg::NODE_W-1:0]    node,
        input logic [rrla_pkg::IN_ADDR_W-1:0] addr);
        t_lock_result r;
        int           k;
        int           idx;
        r        = '0;
        r.status = rrla_pkg::ST_OK;
        case (op)
            rrla_pkg::OP_ADD: begin
                if (int'(node) < NODES) begin
                    if (slot_valid[node]) begin
                        r.status = rrla_pkg::ST_ADD_TAKEN;
                    end else begin
                        slot_valid[node] = 1'b1;
                        slot_addr[node]  = addr;
                    end
                end
            end
            rrla_pkg::OP_REMOVE: begin
                if (int'(node) < NODES) begin
                    if (!slot_valid[node]) begin
                        r.status = rrla_pkg::ST_REMOVE_EMPTY;
                    end else begin
                        slot_valid[node] = 1'b0;
                        if (!any_slot()) begin
                            grant_busy = 1'b0;
                        end
                    end
                end
            end
            rrla_pkg::OP_ADVANCE: begin
                // search starts just past the holder, so the holder comes last
                grant_busy = 1'b0;
                for (k = 1; k <= NODES; k++) begin
                    idx = (holder_idx + k) % NODES;
                    if (slot_valid[idx] && !grant_busy) begin
                        holder_idx = idx;
                        grant_busy = 1'b1;
                    end
                end
                if (!grant_busy) begin
                    r.status = rrla_pkg::ST_ADVANCE_NONE;
                end
            end
            rrla_pkg::OP_SET_ISSUED: begin
                issued_addr = addr;
            end
            default: begin
            end
        endcase
        r.busy        = grant_busy;
        r.holder      = holder_idx[rrla_pkg::NODE_W-1:0];
        r.holder_addr = grant_busy ? slot_addr[holder_idx] : '0;
        r.any_req     = any_slot();
        for (k = int'(node) + 1; k < NODES; k++) begin
            if (slot_valid[k] && slot_addr[k] == addr) begin
                r.succ = 1'b1;
            end
        end
        r.issued_hit = (issued_addr == addr);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                slot_valid[i] = 1'b0;
                slot_addr[i]  = '0;
            end
            holder_idx  = NODES - 1;
            grant_busy  = 1'b0;
            issued_addr = '0;
            lock_results_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (lock_results_q.size() == 0) begin
                    $display("%0t ns: result word with none expected, got %h/%h",
                             $time, i_m_tuser, i_m_tdata);
                    n_fail++;
                end else begin
                    want_r = lock_results_q.pop_front();
                    got_r  = {i_m_tuser, i_m_tdata[0], i_m_tdata[4:1], i_m_tdata[52:5],
                              i_m_tdata[53], i_m_tdata[54], i_m_tdata[55]};
                    check_field("status", want_r.status, got_r.status);
                    check_field("busy_res", want_r.busy, got_r.busy);
                    check_field("holder_node", want_r.holder, got_r.holder);
                    check_field("holder_address", want_r.holder_addr, got_r.holder_addr);
                    check_field("any_request", want_r.any_req, got_r.any_req);
                    check_field("successor_found", want_r.succ, got_r.succ);
                    check_field("issued_match", want_r.issued_hit, got_r.issued_hit);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                lock_results_q.push_back(apply_lock_op(i_s_tuser, i_s_tdata[3:0],
                                                       i_s_tdata[51:4]));
            end
        end
        o_pending    <= lock_results_q.size();
        o_fail_count <= n_fail;
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives request words into the round-robin lock arbiter. A directed opening
// covers the corner cases, then random traffic, mostly over a small address pool,
// follows. Random gaps appear on both sides, and one long hold-off on the
// result side fills the block. The checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 16;
    localparam int N_RANDOM = 1580;
    localparam logic [rrla_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [rrla_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [rrla_pkg::IN_ADDR_W-1:0] ADDR_ONES = '1;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // node[3:0], line_address[51:4], zero[55:52]
    logic [2:0]  s_tuser  = '0;   // operation[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // busy_res[0], holder_node[4:1], holder_address[52:5], any_request[53],
    // successor_found[54], issued_match[55]
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;         // status[1:0]

    int fail_count;
    int pending;
    bit calm_tx = 1'b0;
    int n_taken = 0;
    logic [rrla_pkg::IN_ADDR_W-1:0] addr_pool[4];

    round_robin_lock_arbiter #(.NODES(NODES), .ADDR_BITS(rrla_pkg::IN_ADDR_W)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    lock_arbiter_checker #(.NODES(NODES)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [rrla_pkg::IN_ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return addr_pool[$urandom_range(0, 3)];
        end else if (r < 85) begin
            return rrla_pkg::IN_ADDR_W'({$urandom, $urandom});
        end else if (r < 92) begin
            return '0;
        end
        return ADDR_ONES;
    endfunction

    // Offer one word after an optional gap; hold it until taken.
    task automatic send_word(input logic [rrla_pkg::OP_W-1:0] op,
                             input logic [rrla_pkg::NODE_W-1:0] node,
                             input logic [rrla_pkg::IN_ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap(calm_tx);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, addr, node};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random_word();
        int                         r;
        logic [rrla_pkg::OP_W-1:0]  op;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            op = rrla_pkg::OP_ADD;
        end else if (r < 55) begin
            op = rrla_pkg::OP_REMOVE;
        end else if (r < 72) begin
            op = rrla_pkg::OP_ADVANCE;
        end else if (r < 85) begin
            op = rrla_pkg::OP_QUERY;
        end else if (r < 93) begin
            op = rrla_pkg::OP_SET_ISSUED;
        end else begin
            op = rrla_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        send_word(op, rrla_pkg::NODE_W'($urandom_range(0, NODES - 1)), pick_addr());
    endtask

    // Result side: random stalls, one long hold-off to back the block up.
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = pick_gap((n_taken / 80) % 4 == 3);
            if (n_taken == 300) begin
                stall = 400;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            n_taken++;
        end
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < 4; i++) begin
            addr_pool[i] = rrla_pkg::IN_ADDR_W'({$urandom, $urandom});
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: issued compare at zero, advance and remove with nothing
        send_word(rrla_pkg::OP_QUERY, 4'd0, '0);
        send_word(rrla_pkg::OP_ADVANCE, 4'd15, ADDR_ONES);
        send_word(rrla_pkg::OP_REMOVE, 4'd3, addr_pool[0]);
        // fill a few slots, one twice
        send_word(rrla_pkg::OP_ADD, 4'd0, ADDR_ONES);
        send_word(rrla_pkg::OP_ADD, 4'd0, '0);
        send_word(rrla_pkg::OP_ADD, 4'd15, addr_pool[1]);
        send_word(rrla_pkg::OP_ADD, 4'd7, ADDR_ONES);
        // successor search above and at the last match
        send_word(rrla_pkg::OP_QUERY, 4'd0, ADDR_ONES);
        send_word(rrla_pkg::OP_QUERY, 4'd7, ADDR_ONES);
        send_word(rrla_pkg::OP_QUERY, 4'd15, addr_pool[1]);
        // grant walks 0, 7, 15 and wraps
        send_word(rrla_pkg::OP_ADVANCE, 4'd0, '0);
        send_word(rrla_pkg::OP_ADVANCE, 4'd0, '0);
        send_word(rrla_pkg::OP_ADVANCE, 4'd0, '0);
        send_word(rrla_pkg::OP_ADVANCE, 4'd0, '0);
        // drop the holder while others remain: grant stays held
        send_word(rrla_pkg::OP_REMOVE, 4'd0, '0);
        send_word(rrla_pkg::OP_SET_ISSUED, 4'd0, ADDR_ONES);
        send_word(rrla_pkg::OP_QUERY, 4'd15, ADDR_ONES);
        send_word(OP_SPARE_LO, 4'd5, ADDR_ONES);
        send_word(OP_SPARE_LO + 3'd1, 4'd10, addr_pool[2]);
        send_word(OP_SPARE_HI, 4'd15, '0);
        // empty the table: grant released
        send_word(rrla_pkg::OP_REMOVE, 4'd7, '0);
        send_word(rrla_pkg::OP_REMOVE, 4'd15, '0);
        send_word(rrla_pkg::OP_ADVANCE, 4'd0, '0);
        send_word(rrla_pkg::OP_SET_ISSUED, 4'd0, 48'h5555_5555_5555);

        for (int i = 0; i < N_RANDOM; i++) begin
            calm_tx = ((i / 100) % 5 == 2);
            send_random_word();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (NODES + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rrla_pkg.sv
hdl/rrla_cell.sv
hdl/round_robin_lock_arbiter.sv
bench/lock_arbiter_checker.sv
bench/tb.sv
